>>> src/pdlqr_pkg.sv
// Shared types, constants and helpers for the PD/LQR balance controller.
// Used by pdlqr_csr, pdlqr_core and pd_lqr_balance_controller; no dependencies.
package pdlqr_pkg;

   // Field widths
   localparam int GAIN_W   = 16;
   localparam int POS_W    = 24;
   localparam int PITCH_W  = 16;
   localparam int VEL_W    = 20;
   localparam int RATE_W   = 20;
   localparam int OUT_W    = 24;
   localparam int ERR_W    = PITCH_W + 1;
   localparam int SHIFT_Q  = 10;

   // Stream widths
   localparam int REQ_DATA_W = POS_W + PITCH_W + VEL_W + RATE_W;
   localparam int RSP_DATA_W = 3 * OUT_W;
   localparam int RSP_USER_W = 1;

   // Register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Saturation input width: widest intermediate (negated LQR sum)
   localparam int SAT_IN_W = 43;

   // |pitch| limit, 1.4 rad in Q3.12, truncated
   localparam logic signed [PITCH_W-1:0] SAFE_LIMIT = 16'sd5734;

   // Register indexes, word-aligned at 4*index
   typedef enum logic [2:0] {
      REG_PD_KP           = 3'd0,
      REG_PD_KD           = 3'd1,
      REG_GAIN_POSITION   = 3'd2,
      REG_GAIN_PITCH      = 3'd3,
      REG_GAIN_VELOCITY   = 3'd4,
      REG_GAIN_PITCH_RATE = 3'd5,
      REG_USE_PD          = 3'd6,
      REG_PITCH_TARGET    = 3'd7
   } reg_index_type;

   // Reset values
   localparam logic [GAIN_W-1:0]  PD_KP_RESET           = 16'd4096;
   localparam logic [GAIN_W-1:0]  PD_KD_RESET           = 16'd5120;
   localparam logic [GAIN_W-1:0]  GAIN_POSITION_RESET   = 16'd324;
   localparam logic [GAIN_W-1:0]  GAIN_PITCH_RESET      = 16'd3495;
   localparam logic [GAIN_W-1:0]  GAIN_VELOCITY_RESET   = 16'd709;
   localparam logic [GAIN_W-1:0]  GAIN_PITCH_RATE_RESET = 16'd1875;
   localparam logic               USE_PD_RESET          = 1'b1;
   localparam logic [PITCH_W-1:0] PITCH_TARGET_RESET    = 16'd0;

   typedef struct packed {
      logic signed [GAIN_W-1:0]  pd_kp;
      logic signed [GAIN_W-1:0]  pd_kd;
      logic signed [GAIN_W-1:0]  gain_position;
      logic signed [GAIN_W-1:0]  gain_pitch;
      logic signed [GAIN_W-1:0]  gain_velocity;
      logic signed [GAIN_W-1:0]  gain_pitch_rate;
      logic                      use_pd;
      logic signed [PITCH_W-1:0] pitch_target;
   } cfg_type;

   typedef struct packed {
      logic signed [RATE_W-1:0]  pitch_rate;
      logic signed [VEL_W-1:0]   velocity;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [POS_W-1:0]   position;
   } sample_type;

   typedef struct packed {
      logic                    in_safe_range;
      logic signed [OUT_W-1:0] lqr_effort;
      logic signed [OUT_W-1:0] pd_effort;
      logic signed [OUT_W-1:0] wheel_command;
   } result_type;

   // Clamp a wide signed value to the signed output range
   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_IN_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v[SAT_IN_W-1:OUT_W-1] == {(SAT_IN_W-OUT_W+1){v[SAT_IN_W-1]}}) begin
         r = v[OUT_W-1:0];
      end else if (v[SAT_IN_W-1]) begin
         r = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(OUT_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

>>> src/pdlqr_csr.sv
// Control register file behind the APB-style port: gains, mode and pitch target.
// Depends on pdlqr_pkg.
module pdlqr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pdlqr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pdlqr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pdlqr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output pdlqr_pkg::cfg_type                cfg
);

   pdlqr_pkg::cfg_type       cfg_ff;
   pdlqr_pkg::cfg_type       cfg_in;
   pdlqr_pkg::reg_index_type index;
   logic                     write_en;

   assign index    = pdlqr_pkg::reg_index_type'(csr_paddr[4:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   // Decode the write word into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            pdlqr_pkg::REG_PD_KP:           cfg_in.pd_kp           = csr_pwdata[15:0];
            pdlqr_pkg::REG_PD_KD:           cfg_in.pd_kd           = csr_pwdata[15:0];
            pdlqr_pkg::REG_GAIN_POSITION:   cfg_in.gain_position   = csr_pwdata[15:0];
            pdlqr_pkg::REG_GAIN_PITCH:      cfg_in.gain_pitch      = csr_pwdata[15:0];
            pdlqr_pkg::REG_GAIN_VELOCITY:   cfg_in.gain_velocity   = csr_pwdata[15:0];
            pdlqr_pkg::REG_GAIN_PITCH_RATE: cfg_in.gain_pitch_rate = csr_pwdata[15:0];
            pdlqr_pkg::REG_USE_PD:          cfg_in.use_pd          = csr_pwdata[0];
            pdlqr_pkg::REG_PITCH_TARGET:    cfg_in.pitch_target    = csr_pwdata[15:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pd_kp           <= pdlqr_pkg::PD_KP_RESET;
         cfg_ff.pd_kd           <= pdlqr_pkg::PD_KD_RESET;
         cfg_ff.gain_position   <= pdlqr_pkg::GAIN_POSITION_RESET;
         cfg_ff.gain_pitch      <= pdlqr_pkg::GAIN_PITCH_RESET;
         cfg_ff.gain_velocity   <= pdlqr_pkg::GAIN_VELOCITY_RESET;
         cfg_ff.gain_pitch_rate <= pdlqr_pkg::GAIN_PITCH_RATE_RESET;
         cfg_ff.use_pd          <= pdlqr_pkg::USE_PD_RESET;
         cfg_ff.pitch_target    <= pdlqr_pkg::PITCH_TARGET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register, zero-extended
   always_comb begin
      case (index)
         pdlqr_pkg::REG_PD_KP:           csr_prdata = 32'(unsigned'(cfg_ff.pd_kp));
         pdlqr_pkg::REG_PD_KD:           csr_prdata = 32'(unsigned'(cfg_ff.pd_kd));
         pdlqr_pkg::REG_GAIN_POSITION:   csr_prdata = 32'(unsigned'(cfg_ff.gain_position));
         pdlqr_pkg::REG_GAIN_PITCH:      csr_prdata = 32'(unsigned'(cfg_ff.gain_pitch));
         pdlqr_pkg::REG_GAIN_VELOCITY:   csr_prdata = 32'(unsigned'(cfg_ff.gain_velocity));
         pdlqr_pkg::REG_GAIN_PITCH_RATE: csr_prdata = 32'(unsigned'(cfg_ff.gain_pitch_rate));
         pdlqr_pkg::REG_USE_PD:          csr_prdata = 32'(cfg_ff.use_pd);
         pdlqr_pkg::REG_PITCH_TARGET:    csr_prdata = 32'(unsigned'(cfg_ff.pitch_target));
         default:                        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> src/pdlqr_core.sv
// Combinational PD and LQR effort computation for one sample, plus command select.
// Depends on pdlqr_pkg.
module pdlqr_core (
   input  pdlqr_pkg::cfg_type                        cfg,
   input  pdlqr_pkg::sample_type                     sample,
   input  logic signed [pdlqr_pkg::ERR_W-1:0]        last_error,
   input  logic                                      first_sample,
   output logic signed [pdlqr_pkg::ERR_W-1:0]        error,
   output pdlqr_pkg::result_type                     result
);

   logic signed [pdlqr_pkg::ERR_W-1:0]   prev;
   logic signed [pdlqr_pkg::ERR_W:0]     diff;
   logic signed [32:0]                   prod_kp;
   logic signed [33:0]                   prod_kd;
   logic signed [34:0]                   pd_sum;
   logic signed [24:0]                   pd_q12;
   logic signed [pdlqr_pkg::OUT_W-1:0]   pd_sat;
   logic signed [39:0]                   prod_pos;
   logic signed [31:0]                   prod_pitch;
   logic signed [35:0]                   prod_vel;
   logic signed [35:0]                   prod_rate;
   logic signed [41:0]                   lqr_sum;
   logic signed [42:0]                   lqr_neg;
   logic signed [pdlqr_pkg::OUT_W-1:0]   lqr_sat;
   logic signed [pdlqr_pkg::OUT_W:0]     pd_neg;
   logic                                 safe;

   // Pitch error; derivative term vanishes on the first sample
   assign error = pdlqr_pkg::ERR_W'(cfg.pitch_target) - pdlqr_pkg::ERR_W'(sample.pitch);
   assign prev  = first_sample ? error : last_error;
   assign diff  = (pdlqr_pkg::ERR_W+1)'(error) - (pdlqr_pkg::ERR_W+1)'(prev);

   // PD effort in Q.22, floor to Q.12, clamp
   assign prod_kp = cfg.pd_kp * error;
   assign prod_kd = cfg.pd_kd * diff;
   assign pd_sum  = 35'(prod_kp) + 35'(prod_kd);
   assign pd_q12  = pd_sum[34:pdlqr_pkg::SHIFT_Q];
   assign pd_sat  = pdlqr_pkg::sat_out(pdlqr_pkg::SAT_IN_W'(pd_q12));

   // LQR effort: negated dot product of gains and state
   assign prod_pos   = cfg.gain_position * sample.position;
   assign prod_pitch = cfg.gain_pitch * sample.pitch;
   assign prod_vel   = cfg.gain_velocity * sample.velocity;
   assign prod_rate  = cfg.gain_pitch_rate * sample.pitch_rate;
   assign lqr_sum    = 42'(prod_pos) + 42'(prod_pitch) + 42'(prod_vel) + 42'(prod_rate);
   assign lqr_neg    = -43'(lqr_sum);
   assign lqr_sat    = pdlqr_pkg::sat_out(
                          pdlqr_pkg::SAT_IN_W'($signed(lqr_neg[42:pdlqr_pkg::SHIFT_Q])));

   // Safe pitch window and command select
   assign safe   = (sample.pitch <= pdlqr_pkg::SAFE_LIMIT) &&
                   (sample.pitch >= -pdlqr_pkg::SAFE_LIMIT);
   assign pd_neg = -(pdlqr_pkg::OUT_W+1)'(pd_sat);

   always_comb begin
      result.pd_effort     = pd_sat;
      result.lqr_effort    = lqr_sat;
      result.in_safe_range = safe;
      if (!safe) begin
         result.wheel_command = '0;
      end else if (cfg.use_pd) begin
         result.wheel_command = pdlqr_pkg::sat_out(pdlqr_pkg::SAT_IN_W'(pd_neg));
      end else begin
         result.wheel_command = lqr_sat;
      end
   end

endmodule

>>> src/pd_lqr_balance_controller.sv
// Top level of the PD/LQR balance controller: stream ports, sample and result registers.
// Depends on pdlqr_pkg, pdlqr_csr and pdlqr_core.
//
//  channel  | direction | accepted when                        | word
//  ---------+-----------+--------------------------------------+---------------------------
//  req_     | in        | req_tvalid && req_tready             | one sensor sample
//  rsp_     | out       | rsp_tvalid && rsp_tready             | one control result
//  csr_     | in        | csr_psel && csr_penable && csr_pwrite | one register write
//
// An accepted sample word waits in the sample register; the six multiplies and the sums
// on the multiply/add path between the registers then settle into the result register.
// Throughput is one word per clock while the result stream does not stall; that path sets it.
// Reset (synchronous) empties both registers, restores register defaults and marks the next
// sample as the first. A stalled result holds; the sample register still takes one word
// behind it, and req_tready drops only while both registers are full and rsp_tready is low.
module pd_lqr_balance_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // position[23:0], pitch[39:24], velocity[59:40], pitch_rate[79:60]
   input  logic [pdlqr_pkg::REQ_DATA_W-1:0]      req_tdata,
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // wheel_command[23:0], pd_effort[47:24], lqr_effort[71:48]
   output logic [pdlqr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // in_safe_range[0]
   output logic [pdlqr_pkg::RSP_USER_W-1:0]      rsp_tuser,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pdlqr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pdlqr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pdlqr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   pdlqr_pkg::cfg_type                     cfg;
   pdlqr_pkg::sample_type                  sample_ff;
   logic                                   sample_valid_ff;
   logic                                   sample_valid_in;
   pdlqr_pkg::result_type                  result_ff;
   pdlqr_pkg::result_type                  result_in;
   logic                                   result_valid_ff;
   logic                                   result_valid_in;
   logic signed [pdlqr_pkg::ERR_W-1:0]     last_error_ff;
   logic signed [pdlqr_pkg::ERR_W-1:0]     error;
   logic                                   first_sample_ff;
   logic                                   req_accept;
   logic                                   advance;

   assign csr_pready = 1'b1;

   pdlqr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   pdlqr_core u_core (
      .cfg          (cfg),
      .sample       (sample_ff),
      .last_error   (last_error_ff),
      .first_sample (first_sample_ff),
      .error        (error),
      .result       (result_in)
   );

   // Move the held sample into the result register when that slot frees
   assign advance    = sample_valid_ff && (!result_valid_ff || rsp_tready);
   assign req_tready = !sample_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign sample_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : sample_valid_ff);
   assign result_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : result_valid_ff);

   // Control state and error history
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
         result_valid_ff <= 1'b0;
         last_error_ff   <= '0;
         first_sample_ff <= 1'b1;
      end else begin
         sample_valid_ff <= sample_valid_in;
         result_valid_ff <= result_valid_in;
         if (advance) begin
            last_error_ff   <= error;
            first_sample_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_tdata;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tdata  = {result_ff.lqr_effort, result_ff.pd_effort, result_ff.wheel_command};
   assign rsp_tuser  = result_ff.in_safe_range;

   // A sample that moves on shows up as a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced sample did not reach the result register");

   // Input stalls only when both registers are full and the output is blocked
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (sample_valid_ff && rsp_tvalid && !rsp_tready))
      else $error("input stalled without a full pipeline");

   // Command is forced to zero outside the safe pitch window
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[23:0] == '0))
      else $error("nonzero wheel command outside safe range");

   // The first-sample mark clears once a sample has been processed
   assert property (@(posedge clock) disable iff (reset)
      advance |=> !first_sample_ff)
      else $error("first-sample mark still set after a sample");

endmodule

>>> tb/pd_lqr_balance_controller_tb.sv
// Self-checking bench for pd_lqr_balance_controller: drives sensor sample words, programs
// the gains over the register port and checks every control result against its own model.
// Depends on pdlqr_pkg and the RTL of pd_lqr_balance_controller.
module pd_lqr_balance_controller_tb;
   import pdlqr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 89;
   localparam int RANDOM_PHASES = 6;
   localparam int LONG_STALL = 250;
   localparam int MAX_PRINTS = 40;

   // Predicts PD and LQR efforts and the wheel command; holds the expected result words
   class effort_predictor;
      cfg_type gains;
      logic signed [ERR_W-1:0] last_err;
      bit first;
      result_type expected_efforts[$];
      int errors;
      int checked;
      int taken;

      function new();
         gains.pd_kp = PD_KP_RESET;
         gains.pd_kd = PD_KD_RESET;
         gains.gain_position = GAIN_POSITION_RESET;
         gains.gain_pitch = GAIN_PITCH_RESET;
         gains.gain_velocity = GAIN_VELOCITY_RESET;
         gains.gain_pitch_rate = GAIN_PITCH_RATE_RESET;
         gains.use_pd = USE_PD_RESET;
         gains.pitch_target = PITCH_TARGET_RESET;
         last_err = '0;
         first = 1'b1;
         errors = 0;
         checked = 0;
         taken = 0;
      endfunction

      // Mirror a register write; upper data bits fall away
      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            REG_PD_KP:           gains.pd_kp = v[GAIN_W-1:0];
            REG_PD_KD:           gains.pd_kd = v[GAIN_W-1:0];
            REG_GAIN_POSITION:   gains.gain_position = v[GAIN_W-1:0];
            REG_GAIN_PITCH:      gains.gain_pitch = v[GAIN_W-1:0];
            REG_GAIN_VELOCITY:   gains.gain_velocity = v[GAIN_W-1:0];
            REG_GAIN_PITCH_RATE: gains.gain_pitch_rate = v[GAIN_W-1:0];
            REG_USE_PD:          gains.use_pd = v[0];
            REG_PITCH_TARGET:    gains.pitch_target = v[PITCH_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_out(longint v);
         longint hi;
         hi = (longint'(1) << (OUT_W - 1)) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      // Compute the result of one accepted sample word and advance the error history
      function void take_sample(logic [REQ_DATA_W-1:0] word);
         sample_type s;
         longint err, prev, pit, lim, pd_sum, lqr_sum, pd, lqr, cmd;
         bit safe;
         result_type r;
         s = word;
         pit = longint'($signed(s.pitch));
         err = longint'($signed(gains.pitch_target)) - pit;
         prev = first ? err : longint'(last_err);
         pd_sum = longint'($signed(gains.pd_kp)) * err
                + longint'($signed(gains.pd_kd)) * (err - prev);
         lqr_sum = -(longint'($signed(gains.gain_position)) * longint'($signed(s.position))
                   + longint'($signed(gains.gain_pitch)) * pit
                   + longint'($signed(gains.gain_velocity)) * longint'($signed(s.velocity))
                   + longint'($signed(gains.gain_pitch_rate))
                     * longint'($signed(s.pitch_rate)));
         pd = clamp_out(pd_sum >>> SHIFT_Q);
         lqr = clamp_out(lqr_sum >>> SHIFT_Q);
         lim = longint'(SAFE_LIMIT);
         safe = (pit <= lim) && (pit >= -lim);
         cmd = 0;
         if (safe) cmd = gains.use_pd ? clamp_out(-pd) : lqr;
         r.wheel_command = cmd[OUT_W-1:0];
         r.pd_effort = pd[OUT_W-1:0];
         r.lqr_effort = lqr[OUT_W-1:0];
         r.in_safe_range = safe;
         last_err = err[ERR_W-1:0];
         first = 1'b0;
         expected_efforts.push_back(r);
         taken++;
      endfunction

      task report(string what, longint got, longint want);
         if (errors < MAX_PRINTS)
            $display("mismatch on result %0d: %s is %0d, expected %0d",
                     checked, what, got, want);
         errors++;
      endtask

      // Compare one accepted result word with the oldest expectation
      task check_result(logic [RSP_DATA_W-1:0] data, logic [RSP_USER_W-1:0] user);
         result_type got, want;
         got = {user[0], data};
         if (expected_efforts.size() == 0) begin
            report("result word with no sample pending, wheel_command",
                   $signed(got.wheel_command), 0);
         end else begin
            want = expected_efforts.pop_front();
            if (got.wheel_command !== want.wheel_command)
               report("wheel_command", $signed(got.wheel_command), $signed(want.wheel_command));
            if (got.pd_effort !== want.pd_effort)
               report("pd_effort", $signed(got.pd_effort), $signed(want.pd_effort));
            if (got.lqr_effort !== want.lqr_effort)
               report("lqr_effort", $signed(got.lqr_effort), $signed(want.lqr_effort));
            if (got.in_safe_range !== want.in_safe_range)
               report("in_safe_range", got.in_safe_range, want.in_safe_range);
         end
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   effort_predictor sb = new();
   bit jitter_on = 1'b1;
   int rsp_hold_cycles = 0;
   int csr_writes = 0;
   int settings = 0;
   int quiet_cycles = 0;

   pd_lqr_balance_controller DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Check each result word as it is accepted
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // End the run when no handshake of any kind happens for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result receiver: random stall per word, one long hold when requested
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = jitter_on ? $urandom_range(0, 14) : 0;
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [REQ_DATA_W-1:0] make_sample(int pos, int pit, int vel, int rate);
      sample_type s;
      s.position = POS_W'(pos);
      s.pitch = PITCH_W'(pit);
      s.velocity = VEL_W'(vel);
      s.pitch_rate = RATE_W'(rate);
      return s;
   endfunction

   function automatic int draw_field(int w);
      int r;
      case ($urandom_range(0, 7))
         0: r = (1 << (w - 1)) - 1;
         1: r = -(1 << (w - 1));
         2, 3: r = int'($urandom_range(0, 8191)) - 4096;
         default: r = $urandom;
      endcase
      return r;
   endfunction

   // Mostly inside the safe band, with its edges and the full range mixed in
   function automatic int draw_pitch();
      int r;
      case ($urandom_range(0, 9))
         0, 1: r = $urandom;
         2: begin
            case ($urandom_range(0, 5))
               0: r = 5734;
               1: r = 5735;
               2: r = -5734;
               3: r = -5735;
               4: r = 32767;
               default: r = -32768;
            endcase
         end
         default: r = int'($urandom_range(0, 11468)) - 5734;
      endcase
      return r;
   endfunction

   function automatic logic [GAIN_W-1:0] draw_gain();
      logic [GAIN_W-1:0] g;
      case ($urandom_range(0, 6))
         0: g = 16'h7fff;
         1: g = 16'h8000;
         2: g = 16'h0000;
         3, 4: g = 16'($urandom_range(0, 8191)) - 16'd4096;
         default: g = 16'($urandom);
      endcase
      return g;
   endfunction

   function automatic cfg_type draw_config(bit pd_mode);
      cfg_type c;
      c.pd_kp = draw_gain();
      c.pd_kd = draw_gain();
      c.gain_position = draw_gain();
      c.gain_pitch = draw_gain();
      c.gain_velocity = draw_gain();
      c.gain_pitch_rate = draw_gain();
      c.use_pd = pd_mode;
      case ($urandom_range(0, 5))
         0: c.pitch_target = 16'h7fff;
         1: c.pitch_target = 16'h8000;
         default: c.pitch_target = 16'($urandom_range(0, 4095)) - 16'd2048;
      endcase
      return c;
   endfunction

   // Offer one sample word after a random gap; hold it until accepted
   task automatic send_sample(logic [REQ_DATA_W-1:0] word);
      int gap;
      gap = jitter_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      sb.take_sample(word);
   endtask

   // Stop offering and wait until every expected result word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_efforts.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_writes++;
   endtask

   // Program every register while the block is idle; junk in the upper data bits
   task automatic write_config(cfg_type c);
      drain();
      csr_write(REG_PD_KP, {16'($urandom), c.pd_kp});
      csr_write(REG_PD_KD, {16'($urandom), c.pd_kd});
      csr_write(REG_GAIN_POSITION, {16'($urandom), c.gain_position});
      csr_write(REG_GAIN_PITCH, {16'($urandom), c.gain_pitch});
      csr_write(REG_GAIN_VELOCITY, {16'($urandom), c.gain_velocity});
      csr_write(REG_GAIN_PITCH_RATE, {16'($urandom), c.gain_pitch_rate});
      csr_write(REG_USE_PD, {31'($urandom), c.use_pd});
      csr_write(REG_PITCH_TARGET, {16'($urandom), c.pitch_target});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      settings++;
   endtask

   initial begin
      cfg_type c;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset gains: first sample has no derivative, then the safe band edges and extremes
      send_sample(make_sample(0, 0, 0, 0));
      send_sample(make_sample(4096, 1000, -2048, 512));
      send_sample(make_sample(-100, 5734, 100, -300));
      send_sample(make_sample(200, 5735, -100, 300));
      send_sample(make_sample(-300, -5734, 50, 50));
      send_sample(make_sample(300, -5735, -50, -50));
      send_sample(make_sample(8388607, 32767, 524287, 524287));
      send_sample(make_sample(-8388608, -32768, -524288, -524288));
      send_sample(make_sample(0, 0, 0, 0));

      // Extreme gains in LQR mode: both saturation directions
      c = '{pd_kp: 16'h8000, pd_kd: 16'h8000, gain_position: 16'h7fff,
            gain_pitch: 16'h7fff, gain_velocity: 16'h7fff, gain_pitch_rate: 16'h7fff,
            use_pd: 1'b0, pitch_target: 16'h7fff};
      write_config(c);
      send_sample(make_sample(8388607, 32767, 524287, 524287));
      send_sample(make_sample(-8388608, -32768, -524288, -524288));
      send_sample(make_sample(8388607, 100, 524287, 524287));
      send_sample(make_sample(-8388608, -100, -524288, -524288));
      send_sample(make_sample(0, 0, 0, 0));

      // Opposite extremes in PD mode: largest error swings
      c = '{pd_kp: 16'h7fff, pd_kd: 16'h7fff, gain_position: 16'h8000,
            gain_pitch: 16'h8000, gain_velocity: 16'h8000, gain_pitch_rate: 16'h8000,
            use_pd: 1'b1, pitch_target: 16'h8000};
      write_config(c);
      send_sample(make_sample(8388607, 32767, 524287, 524287));
      send_sample(make_sample(-8388608, -32768, -524288, -524288));
      send_sample(make_sample(1, 5734, -1, 1));
      send_sample(make_sample(-1, -5734, 1, -1));
      send_sample(make_sample(8388607, 32767, -524288, 524287));

      // Random phases, one setting each, alternating PD and LQR mode
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_config(draw_config(phase[0]));
         if (phase == 1) begin
            jitter_on = 1'b0;
            rsp_hold_cycles = LONG_STALL;
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 25 == 0 && !(phase == 1 && i == 0))
               jitter_on = ($urandom_range(0, 3) != 0);
            if (phase == 3 && i == 40) drain();
            send_sample(make_sample(draw_field(POS_W), draw_pitch(),
                                    draw_field(VEL_W), draw_field(RATE_W)));
         end
      end

      // Let the pipeline empty, then give any stray word time to show up
      drain();
      repeat (6) @(posedge clock);

      $display("covered %0d samples and %0d result words over %0d gain settings",
               sb.taken, sb.checked, settings + 1);
      $display("%0d register writes, one long receiver stall, jitter on and off",
               csr_writes);
      if (sb.errors == 0 && sb.expected_efforts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors,
                  sb.expected_efforts.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
